// ===== hw/rtl/fpalu_pkg.sv =====
// shared types, constants and helpers for the fixed-point alu
`default_nettype none
package fpalu_pkg;

  localparam int WORD_W    = 32;
  localparam int FRAC_BITS = 8;
  // numerator bits of a divide, one quotient bit per cell
  localparam int NQ_W      = WORD_W + FRAC_BITS;
  localparam int NCELL     = NQ_W;
  localparam int MAG_W     = 2 * WORD_W + 1;

  localparam logic [WORD_W-1:0] SAT_POS = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] SAT_NEG = {1'b1, {(WORD_W-1){1'b0}}};

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_GT       = 4'd4,
    OP_LT       = 4'd5,
    OP_GE       = 4'd6,
    OP_LE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_FROM_INT = 4'd14,
    OP_TO_INT   = 4'd15
  } op_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] result_raw;
    logic               compare_true;
    logic               overflow;
    logic               divide_by_zero;
  } out_word_t;

  // word travelling down the cell chain
  typedef struct packed {
    logic              vld;
    op_t               op;
    logic              neg;
    logic [WORD_W-1:0] den;
    logic [WORD_W-1:0] rem;
    logic [NQ_W-1:0]   nq;
    logic [2*WORD_W-1:0] prod;
    logic [WORD_W-1:0] res;
    logic              cmp;
    logic              ovf;
    logic              dbz;
  } cell_t;

  typedef struct packed {
    logic [WORD_W-1:0] val;
    logic              ovf;
  } pack_t;

  // apply a sign to a magnitude, saturating to the word range
  function automatic pack_t pack(input logic neg, input logic [MAG_W-1:0] mag);
    logic [MAG_W-1:0] limit;
    pack_t            p;
    limit = (MAG_W'(1) << (WORD_W - 1)) - (neg ? MAG_W'(0) : MAG_W'(1));
    if (mag > limit) begin
      p.ovf = 1'b1;
      p.val = neg ? SAT_NEG : SAT_POS;
    end else begin
      p.ovf = 1'b0;
      p.val = neg ? WORD_W'(-mag[WORD_W-1:0]) : mag[WORD_W-1:0];
    end
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/fpalu_pre.sv =====
// front stage: decode, multiply and all operations that do not use the divide cells
`default_nettype none
module fpalu_pre (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              adv,
  input  wire logic              vld,
  input  wire fpalu_pkg::in_word_t word,
  output fpalu_pkg::cell_t       cur
);

  fpalu_pkg::cell_t   nxt;
  logic signed [31:0] a;
  logic signed [31:0] b;
  logic [31:0]        ma;
  logic [31:0]        mb;
  logic signed [32:0] sum;
  logic signed [32:0] dif;
  logic signed [32:0] incr;
  logic signed [32:0] decr;
  logic               lt;
  fpalu_pkg::pack_t   pk_from;
  fpalu_pkg::pack_t   pk_to;

  assign a  = word.operand_a;
  assign b  = word.operand_b;
  assign ma = a[31] ? 32'(-a) : a;
  assign mb = b[31] ? 32'(-b) : b;

  // widened add and subtract for saturation checks
  assign sum  = {a[31], a} + {b[31], b};
  assign dif  = {a[31], a} - {b[31], b};
  assign incr = {a[31], a} + 33'sd1;
  assign decr = {a[31], a} - 33'sd1;
  assign lt   = a < b;

  assign pk_from = fpalu_pkg::pack(a[31],
    fpalu_pkg::MAG_W'({ma, {fpalu_pkg::FRAC_BITS{1'b0}}}));
  assign pk_to   = fpalu_pkg::pack(a[31],
    fpalu_pkg::MAG_W'(ma >> fpalu_pkg::FRAC_BITS));

  // next word for the first cell
  always_comb begin
    nxt      = '0;
    nxt.vld  = vld;
    nxt.op   = word.op;
    nxt.neg  = a[31] ^ b[31];
    nxt.den  = mb;
    nxt.rem  = '0;
    nxt.nq   = {ma, {fpalu_pkg::FRAC_BITS{1'b0}}};
    nxt.prod = 64'(ma) * 64'(mb);
    unique case (word.op)
      fpalu_pkg::OP_ADD: begin
        nxt.ovf = sum[32] ^ sum[31];
        nxt.res = nxt.ovf ? (a[31] ? fpalu_pkg::SAT_NEG : fpalu_pkg::SAT_POS) : sum[31:0];
      end
      fpalu_pkg::OP_SUB: begin
        nxt.ovf = dif[32] ^ dif[31];
        nxt.res = nxt.ovf ? (a[31] ? fpalu_pkg::SAT_NEG : fpalu_pkg::SAT_POS) : dif[31:0];
      end
      fpalu_pkg::OP_MUL: nxt.res = '0;
      fpalu_pkg::OP_DIV: begin
        if (b == 32'sd0) begin
          nxt.dbz = 1'b1;
          nxt.ovf = 1'b1;
          nxt.res = a[31] ? fpalu_pkg::SAT_NEG : fpalu_pkg::SAT_POS;
        end
      end
      fpalu_pkg::OP_GT:  nxt.cmp = b < a;
      fpalu_pkg::OP_LT:  nxt.cmp = lt;
      fpalu_pkg::OP_GE:  nxt.cmp = !lt;
      fpalu_pkg::OP_LE:  nxt.cmp = !(b < a);
      fpalu_pkg::OP_EQ:  nxt.cmp = a == b;
      fpalu_pkg::OP_NE:  nxt.cmp = a != b;
      fpalu_pkg::OP_MIN: nxt.res = lt ? a : b;
      fpalu_pkg::OP_MAX: nxt.res = lt ? b : a;
      fpalu_pkg::OP_INC: begin
        nxt.ovf = incr[32] ^ incr[31];
        nxt.res = nxt.ovf ? (a[31] ? fpalu_pkg::SAT_NEG : fpalu_pkg::SAT_POS) : incr[31:0];
      end
      fpalu_pkg::OP_DEC: begin
        nxt.ovf = decr[32] ^ decr[31];
        nxt.res = nxt.ovf ? (a[31] ? fpalu_pkg::SAT_NEG : fpalu_pkg::SAT_POS) : decr[31:0];
      end
      fpalu_pkg::OP_FROM_INT: begin
        nxt.ovf = pk_from.ovf;
        nxt.res = pk_from.val;
      end
      fpalu_pkg::OP_TO_INT: begin
        nxt.ovf = pk_to.ovf;
        nxt.res = pk_to.val;
      end
    endcase
  end

  // stage register, product registered here
  always_ff @(posedge clk) begin
    if (rst) begin
      cur.vld <= 1'b0;
    end else if (adv) begin
      cur <= nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/fpalu_div_cell.sv =====
// one restoring-divide cell: one quotient bit per stage
`default_nettype none
module fpalu_div_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            adv,
  input  wire fpalu_pkg::cell_t prev,
  output fpalu_pkg::cell_t     cur
);

  fpalu_pkg::cell_t nxt;
  logic [32:0]      r_sh;
  logic             ge;
  logic [32:0]      r_sub;

  // shift in next numerator bit, trial subtract
  assign r_sh  = {prev.rem, prev.nq[fpalu_pkg::NQ_W-1]};
  assign ge    = r_sh >= {1'b0, prev.den};
  assign r_sub = r_sh - {1'b0, prev.den};

  always_comb begin
    nxt     = prev;
    nxt.rem = ge ? r_sub[31:0] : r_sh[31:0];
    nxt.nq  = {prev.nq[fpalu_pkg::NQ_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.vld <= 1'b0;
    end else if (adv) begin
      cur <= nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/fpalu_post.sv =====
// back stage: rounding and saturation of multiply and divide, output register
`default_nettype none
module fpalu_post (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             adv,
  input  wire fpalu_pkg::cell_t last,
  output logic                  res_valid,
  output fpalu_pkg::out_word_t  res_word
);

  logic [fpalu_pkg::MAG_W-1:0] mr;
  logic [fpalu_pkg::NQ_W:0]    dq;
  logic [32:0]                 diff;
  logic                        up;
  fpalu_pkg::pack_t            pk_mul;
  fpalu_pkg::pack_t            pk_div;
  fpalu_pkg::out_word_t        nxt;

  // multiply: round half away from zero, drop fraction
  assign mr = ({1'b0, last.prod} +
               (fpalu_pkg::MAG_W'(1) << (fpalu_pkg::FRAC_BITS - 1))) >> fpalu_pkg::FRAC_BITS;
  assign pk_mul = fpalu_pkg::pack(last.neg, mr);

  // divide: round up when remainder is at least half the divisor
  assign diff   = {1'b0, last.den} - {1'b0, last.rem};
  assign up     = {1'b0, last.rem} >= diff;
  assign dq     = {1'b0, last.nq} + (fpalu_pkg::NQ_W + 1)'(up);
  assign pk_div = fpalu_pkg::pack(last.neg, fpalu_pkg::MAG_W'(dq));

  always_comb begin
    nxt.result_raw     = last.res;
    nxt.compare_true   = last.cmp;
    nxt.overflow       = last.ovf;
    nxt.divide_by_zero = last.dbz;
    if (last.op == fpalu_pkg::OP_MUL) begin
      nxt.result_raw = pk_mul.val;
      nxt.overflow   = pk_mul.ovf;
    end else if (last.op == fpalu_pkg::OP_DIV && !last.dbz) begin
      nxt.result_raw = pk_div.val;
      nxt.overflow   = pk_div.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= last.vld;
      res_word  <= nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/fixed_point_alu_top.sv =====
// signed q24.8 fixed-point alu, top level
//
//   channel | direction | word                      | handshake
//   op      | in        | op, operand_a, operand_b  | op_valid / op_stall
//   res     | out       | result_raw, flags         | res_valid / res_stall
//
// one word accepted per cycle unless op_stall; every operation
// passes 42 registers: front stage, 40 divide cells (one quotient
// bit each), output register.
// the whole chain advances together; it holds only while a result sits
// unaccepted in the output register, and op_stall follows that.
// reset clears valid bits only.
`default_nettype none
module fixed_point_alu_top (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 op_valid,
  output logic                      op_stall,
  input  wire fpalu_pkg::in_word_t  op_word,
  output logic                      res_valid,
  input  wire logic                 res_stall,
  output fpalu_pkg::out_word_t      res_word
);

  logic             adv;
  fpalu_pkg::cell_t chain [0:fpalu_pkg::NCELL];

  // chain moves unless the output holds a stalled word
  assign adv      = !(res_valid && res_stall);
  assign op_stall = !adv;

  fpalu_pre u_pre (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .vld  (op_valid),
    .word (op_word),
    .cur  (chain[0])
  );

  // divide cells
  for (genvar i = 0; i < fpalu_pkg::NCELL; i++) begin : g_cell
    fpalu_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .adv  (adv),
      .prev (chain[i]),
      .cur  (chain[i+1])
    );
  end

  fpalu_post u_post (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .last      (chain[fpalu_pkg::NCELL]),
    .res_valid (res_valid),
    .res_word  (res_word)
  );

  // checks
  a_dbz_ovf: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_word.divide_by_zero |-> res_word.overflow)
    else $error("divide by zero without overflow");

  a_cmp_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_word.compare_true |-> res_word.result_raw == 32'sd0)
    else $error("comparison with nonzero result");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> $stable(chain[0].vld) && $stable(res_word))
    else $error("chain moved while stalled");

endmodule
`default_nettype wire
